/* hw/rtl/pmu_pkg.sv */
// Shared types and codes of the polynomial multiplier unit.
package pmu_pkg;

	// Operation codes carried in the mode field of a command beat.
	localparam logic [1:0] MODE_LOAD_A = 2'd0;
	localparam logic [1:0] MODE_LOAD_B = 2'd1;
	localparam logic [1:0] MODE_MULT   = 2'd2;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] coeff;
	} cmd_beat_t;

	typedef struct packed {
		logic signed [31:0] product_coeff;
		logic [4:0]         power;
		logic               saturated;
		logic               dropped;
		logic               last;
	} prod_beat_t;

	// Control from the sequencer to the multiply-accumulate unit.
	typedef struct packed {
		logic clear;
		logic term_v;
	} mac_ctrl_t;

	// Rounded and saturated view of the accumulator.
	typedef struct packed {
		logic signed [31:0] value;
		logic               sat;
	} mac_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_ISSUE,
		ST_DRAIN,
		ST_EMIT
	} seq_state_t;

endpackage

/* hw/rtl/pmu_chan_if.sv */
// Valid/ready channel carrying one payload beat.
interface pmu_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/polynomial_multiplier_unit.sv */
// Polynomial multiplier unit: loads two Q16.16 operands and streams their product.
// A load beat (mode 0 for A, mode 1 for B) is stored in that operand's memory; loads past
// MAX_DEG+1 coefficients are dropped and reported on the dropped flag of the next product.
// A multiply beat (mode 2) returns la+lb-1 product beats, lowest power first, with last
// set on the final one, and clears both operands. For each product coefficient the
// sequencer sets up the term range and clears the accumulator, issues one
// multiply-accumulate per cycle, fed by one read port on each operand memory, drains
// the pipeline and then outputs the coefficient. With an empty operand no terms are read.
// No command beat is taken while a multiply is running.
module polynomial_multiplier_unit #(
	parameter int MAX_DEG = 15
) (
	input  logic      clk,
	input  logic      arst_n,
	pmu_chan_if.sink   cmd,
	pmu_chan_if.source prod
);

	localparam int CAP   = MAX_DEG + 1;
	localparam int AW    = $clog2(CAP);
	localparam int CW    = $clog2(CAP + 1);
	localparam int KW    = $clog2(2 * CAP - 1);
	localparam int ACC_W = 64 + AW;

	pmu_pkg::seq_state_t state_q, state_d;

	logic [CW-1:0] count_a_q, count_b_q;
	logic          ovf_q;
	logic [KW-1:0] la_q, lb_q, last_k_q, k_q;
	logic          zero_q, ovf_snap_q;
	logic [AW-1:0] i_q, j_q, i_hi_q;
	logic          rd_v_s1;

	logic          cmd_fire, is_load_a, is_load_b, is_mult;
	logic          full_a, full_b, wr_a, wr_b;
	logic [KW-1:0] la_n, lb_n;
	logic [KW:0]   len_sum;
	logic [KW-1:0] i_lo, i_hi;
	logic          issue, emit_fire, last_k, mac_busy;

	pmu_pkg::mac_ctrl_t  mac_ctrl;
	pmu_pkg::mac_res_t   mac_res;
	pmu_pkg::prod_beat_t out_q;
	logic                out_v_q;
	logic signed [31:0]  a_rd, b_rd;

	assign cmd_fire  = cmd.valid & cmd.ready;
	assign is_load_a = cmd.payload.mode == pmu_pkg::MODE_LOAD_A;
	assign is_load_b = cmd.payload.mode == pmu_pkg::MODE_LOAD_B;
	assign is_mult   = cmd.payload.mode == pmu_pkg::MODE_MULT;
	assign full_a    = count_a_q == CW'(CAP);
	assign full_b    = count_b_q == CW'(CAP);
	assign wr_a      = cmd_fire & is_load_a & ~full_a;
	assign wr_b      = cmd_fire & is_load_b & ~full_b;

	// An empty operand behaves as one zero coefficient.
	assign la_n    = (count_a_q == '0) ? KW'(1) : KW'(count_a_q);
	assign lb_n    = (count_b_q == '0) ? KW'(1) : KW'(count_b_q);
	assign len_sum = (KW + 1)'(la_n) + (KW + 1)'(lb_n) - (KW + 1)'(2);

	// Term range for product coefficient k: max(0, k-lb+1) up to min(k, la-1).
	assign i_lo   = (k_q >= lb_q) ? (k_q - lb_q + KW'(1)) : '0;
	assign i_hi   = (k_q < la_q) ? k_q : (la_q - KW'(1));
	assign last_k = k_q == last_k_q;

	pmu_opram #(.DEPTH(CAP), .AW(AW)) u_mem_a (
		.clk   (clk),
		.we    (wr_a),
		.waddr (count_a_q[AW-1:0]),
		.wdata (cmd.payload.coeff),
		.re    (issue),
		.raddr (i_q),
		.rdata (a_rd)
	);

	pmu_opram #(.DEPTH(CAP), .AW(AW)) u_mem_b (
		.clk   (clk),
		.we    (wr_b),
		.waddr (count_b_q[AW-1:0]),
		.wdata (cmd.payload.coeff),
		.re    (issue),
		.raddr (j_q),
		.rdata (b_rd)
	);

	pmu_mac #(.ACC_W(ACC_W)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.a      (a_rd),
		.b      (b_rd),
		.busy   (mac_busy),
		.res    (mac_res)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pmu_pkg::ST_IDLE: begin
				if (cmd_fire && is_mult) begin
					state_d = pmu_pkg::ST_START;
				end
			end
			pmu_pkg::ST_START: begin
				state_d = zero_q ? pmu_pkg::ST_DRAIN : pmu_pkg::ST_ISSUE;
			end
			pmu_pkg::ST_ISSUE: begin
				if (i_q == i_hi_q) begin
					state_d = pmu_pkg::ST_DRAIN;
				end
			end
			pmu_pkg::ST_DRAIN: begin
				if (!rd_v_s1 && !mac_busy) begin
					state_d = pmu_pkg::ST_EMIT;
				end
			end
			pmu_pkg::ST_EMIT: begin
				if (emit_fire) begin
					state_d = last_k ? pmu_pkg::ST_IDLE : pmu_pkg::ST_START;
				end
			end
			default: state_d = pmu_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.ready       = state_q == pmu_pkg::ST_IDLE;
		issue           = state_q == pmu_pkg::ST_ISSUE;
		mac_ctrl.clear  = state_q == pmu_pkg::ST_START;
		mac_ctrl.term_v = rd_v_s1;
		emit_fire       = (state_q == pmu_pkg::ST_EMIT) && (!out_v_q || prod.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pmu_pkg::ST_IDLE;
			count_a_q <= '0;
			count_b_q <= '0;
			ovf_q     <= 1'b0;
			rd_v_s1   <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= issue;
			if (cmd_fire) begin
				if (is_mult) begin
					count_a_q <= '0;
					count_b_q <= '0;
					ovf_q     <= 1'b0;
				end else if ((is_load_a && full_a) || (is_load_b && full_b)) begin
					ovf_q <= 1'b1;
				end else if (is_load_a) begin
					count_a_q <= count_a_q + CW'(1);
				end else if (is_load_b) begin
					count_b_q <= count_b_q + CW'(1);
				end
			end
			if (emit_fire) begin
				out_v_q <= 1'b1;
			end else if (prod.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Multiply bookkeeping: operand lengths are captured when the multiply beat arrives.
	always_ff @(posedge clk) begin
		if (cmd_fire && is_mult) begin
			la_q       <= la_n;
			lb_q       <= lb_n;
			zero_q     <= (count_a_q == '0) || (count_b_q == '0);
			last_k_q   <= len_sum[KW-1:0];
			ovf_snap_q <= ovf_q;
			k_q        <= '0;
		end else if (emit_fire) begin
			k_q <= k_q + KW'(1);
		end
		if (state_q == pmu_pkg::ST_START) begin
			i_q    <= i_lo[AW-1:0];
			j_q    <= AW'(k_q - i_lo);
			i_hi_q <= i_hi[AW-1:0];
		end else if (issue) begin
			i_q <= i_q + AW'(1);
			j_q <= j_q - AW'(1);
		end
		if (emit_fire) begin
			out_q.product_coeff <= mac_res.value;
			out_q.power         <= 5'(k_q);
			out_q.saturated     <= mac_res.sat;
			out_q.dropped       <= ovf_snap_q;
			out_q.last          <= last_k;
		end
	end

	assign prod.valid   = out_v_q;
	assign prod.payload = out_q;

endmodule

/* hw/rtl/pmu_opram.sv */
// Operand coefficient memory: one write port, one read port, registered read data.
module pmu_opram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic signed [31:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic signed [31:0] rdata
);

	logic signed [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/pmu_mac.sv */
// Multiply-accumulate unit with rounding to Q16.16 and saturation.
module pmu_mac #(
	parameter int ACC_W = 68
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pmu_pkg::mac_ctrl_t  ctrl,
	input  logic signed [31:0]  a,
	input  logic signed [31:0]  b,
	output logic                busy,
	output pmu_pkg::mac_res_t   res
);

	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(32768);

	logic signed [63:0]      prod_s2;
	logic                    prod_v_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] rsum;
	logic [ACC_W-48:0]       hi_bits;
	logic                    fits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_v_s2 <= 1'b0;
		end else begin
			prod_v_s2 <= ctrl.term_v;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.term_v) begin
			prod_s2 <= 64'(a) * 64'(b);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (prod_v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// Round half up, then the result fits when every bit above bit 47 equals bit 47.
	assign rsum    = acc_q + HALF;
	assign hi_bits = rsum[ACC_W-1:47];
	assign fits    = (&hi_bits) | (~|hi_bits);

	always_comb begin
		res.sat = ~fits;
		if (fits) begin
			res.value = rsum[47:16];
		end else if (rsum[ACC_W-1]) begin
			res.value = 32'sh8000_0000;
		end else begin
			res.value = 32'sh7FFF_FFFF;
		end
	end

	assign busy = prod_v_s2;

endmodule

/* tb/tb_polynomial_multiplier_unit.sv */
// Testbench for the polynomial multiplier unit: random loads and multiplies, checked products.
`timescale 1ns / 1ps

module tb_polynomial_multiplier_unit;

	localparam int          MAX_DEG     = 15;
	localparam int          CAP         = MAX_DEG + 1;
	localparam logic [1:0]  MODE_UNUSED = 2'd3;
	localparam int unsigned ITEM_TARGET = 500;
	localparam int unsigned LONG_HOLD   = 600;
	localparam int unsigned DRAIN_WAIT  = 50;
	localparam int unsigned CYCLE_LIMIT = 2000000;

	// Keeps its own copy of both operands and the product beats still owed by the block.
	class product_scoreboard;
		logic signed [31:0]  a_coeffs [CAP];
		logic signed [31:0]  b_coeffs [CAP];
		int unsigned         a_count;
		int unsigned         b_count;
		bit                  load_dropped;
		pmu_pkg::prod_beat_t expected_terms [$];
		int unsigned         errors;

		function void note_command(pmu_pkg::cmd_beat_t beat);
			logic signed [31:0] value;
			value = beat.coeff;
			case (beat.mode)
				pmu_pkg::MODE_LOAD_A: begin
					if (a_count >= CAP) begin
						load_dropped = 1'b1;
					end else begin
						a_coeffs[a_count] = value;
						a_count++;
					end
				end
				pmu_pkg::MODE_LOAD_B: begin
					if (b_count >= CAP) begin
						load_dropped = 1'b1;
					end else begin
						b_coeffs[b_count] = value;
						b_count++;
					end
				end
				pmu_pkg::MODE_MULT: begin
					convolve_operands();
					a_count = 0;
					b_count = 0;
					load_dropped = 1'b0;
				end
				default: begin
				end
			endcase
		endfunction

		// An empty operand acts as a single zero coefficient.
		function void convolve_operands();
			int unsigned         la;
			int unsigned         lb;
			int unsigned         n;
			logic signed [127:0] acc;
			logic signed [127:0] rounded;
			pmu_pkg::prod_beat_t term;
			la = (a_count == 0) ? 1 : a_count;
			lb = (b_count == 0) ? 1 : b_count;
			n = la + lb - 1;
			for (int k = 0; k < n; k++) begin
				acc = '0;
				if (a_count != 0 && b_count != 0) begin
					for (int i = 0; i < la; i++) begin
						if (k >= i && k - i < lb)
							acc += a_coeffs[i] * b_coeffs[k - i];
					end
				end
				// Round half toward plus infinity, then clip to 32 bits.
				rounded = (acc + 128'sd32768) >>> 16;
				term = '0;
				if (rounded > 128'sd2147483647) begin
					term.product_coeff = 32'h7FFF_FFFF;
					term.saturated = 1'b1;
				end else if (rounded < -128'sd2147483648) begin
					term.product_coeff = 32'h8000_0000;
					term.saturated = 1'b1;
				end else begin
					term.product_coeff = rounded[31:0];
				end
				term.power = k[4:0];
				term.dropped = load_dropped;
				term.last = (k == n - 1);
				expected_terms.push_back(term);
			end
		endfunction

		function void report_field(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s expected %h, got %h", $time, field, want, got);
			end
		endfunction

		function void check_product(pmu_pkg::prod_beat_t got);
			pmu_pkg::prod_beat_t want;
			if (expected_terms.size() == 0) begin
				errors++;
				$display("%0t: product beat with none expected: coeff %h, power %0d",
					$time, got.product_coeff, got.power);
				return;
			end
			want = expected_terms.pop_front();
			report_field("product_coeff", want.product_coeff, got.product_coeff);
			report_field("power", 32'(want.power), 32'(got.power));
			report_field("saturated", 32'(want.saturated), 32'(got.saturated));
			report_field("dropped", 32'(want.dropped), 32'(got.dropped));
			report_field("last", 32'(want.last), 32'(got.last));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	pmu_chan_if #(.T(pmu_pkg::cmd_beat_t))  cmd_ch ();
	pmu_chan_if #(.T(pmu_pkg::prod_beat_t)) prod_ch ();

	polynomial_multiplier_unit #(
		.MAX_DEG(MAX_DEG)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.prod(prod_ch)
	);

	product_scoreboard sb = new();

	int unsigned items_sent;
	int unsigned tx_gap_max;
	int unsigned rx_stall_max;
	int unsigned cycle_count;
	bit          rx_hold_req;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Both channels are observed at the same edge; commands are noted before products are checked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready)
				sb.note_command(cmd_ch.payload);
			if (prod_ch.valid && prod_ch.ready)
				sb.check_product(prod_ch.payload);
		end
	end

	task automatic send_cmd(input logic [1:0] m, input logic [31:0] c);
		int unsigned gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.payload <= '{mode: m, coeff: c};
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	// Lets the scoreboard note the beat accepted at the previous edge before polling.
	task automatic wait_for_products();
		@(posedge clk);
		while (sb.expected_terms.size() != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] draw_coeff();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 4))
			0: return r;
			1: return {{15{r[16]}}, r[16:0]};
			2: return r[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
			3: return {{13{r[31]}}, r[2:0], 16'h0000};
			default: return r;
		endcase
	endfunction

	// Mostly short operands, sometimes empty or (nearly) full ones, sometimes more loads than fit.
	function automatic int unsigned draw_length();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return $urandom_range(CAP - 3, CAP);
			2: return $urandom_range(CAP + 1, CAP + 3);
			default: return $urandom_range(1, 5);
		endcase
	endfunction

	task automatic run_sequence();
		int unsigned want_a;
		int unsigned want_b;
		int unsigned sent_a;
		int unsigned sent_b;
		bit          pick_a;
		want_a = draw_length();
		want_b = draw_length();
		sent_a = 0;
		sent_b = 0;
		while (sent_a < want_a || sent_b < want_b) begin
			if ($urandom_range(0, 24) == 0)
				send_cmd(MODE_UNUSED, $urandom);
			pick_a = (sent_b >= want_b) || (sent_a < want_a && $urandom_range(0, 1) == 1);
			send_cmd(pick_a ? pmu_pkg::MODE_LOAD_A : pmu_pkg::MODE_LOAD_B, draw_coeff());
			if (pick_a)
				sent_a++;
			else
				sent_b++;
			items_sent++;
		end
		send_cmd(pmu_pkg::MODE_MULT, $urandom);
		items_sent++;
	endtask

	initial begin : product_sink
		int unsigned stall;
		prod_ch.ready = 1'b0;
		rx_stall_max = 7;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold_req) begin
				stall = LONG_HOLD;
				rx_hold_req <= 1'b0;
			end else begin
				if ($urandom_range(0, 31) == 0)
					rx_stall_max = (rx_stall_max == 0) ? 7 : 0;
				stall = $urandom_range(0, rx_stall_max);
			end
			if (stall != 0) begin
				prod_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			prod_ch.ready <= 1'b1;
			do @(posedge clk); while (!prod_ch.valid);
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		bit hold_issued;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.payload = '0;
		rx_hold_req = 1'b0;
		items_sent = 0;
		tx_gap_max = 7;
		hold_issued = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Both operands empty.
		send_cmd(pmu_pkg::MODE_MULT, 32'h0000_0000);
		// Extreme coefficients: every product term clips, with an ignored beat in between.
		send_cmd(pmu_pkg::MODE_LOAD_A, 32'h7FFF_FFFF);
		send_cmd(pmu_pkg::MODE_LOAD_A, 32'h8000_0000);
		send_cmd(MODE_UNUSED, 32'hFFFF_FFFF);
		send_cmd(pmu_pkg::MODE_LOAD_B, 32'h7FFF_FFFF);
		send_cmd(pmu_pkg::MODE_LOAD_B, 32'h8000_0000);
		send_cmd(pmu_pkg::MODE_MULT, 32'hFFFF_FFFF);
		// Exact half units: one rounds up to 1, the negative one up to 0.
		send_cmd(pmu_pkg::MODE_LOAD_A, 32'h0000_0001);
		send_cmd(pmu_pkg::MODE_LOAD_A, 32'hFFFF_FFFF);
		send_cmd(pmu_pkg::MODE_LOAD_B, 32'h0000_8000);
		send_cmd(pmu_pkg::MODE_MULT, 32'h0000_0000);
		// One load too many into A while B stays empty.
		for (int i = 0; i < CAP + 1; i++)
			send_cmd(pmu_pkg::MODE_LOAD_A, $urandom);
		send_cmd(pmu_pkg::MODE_MULT, $urandom);
		items_sent = 29;

		// The sender goes quiet until the block has returned everything.
		cmd_ch.valid <= 1'b0;
		wait_for_products();

		while (items_sent < ITEM_TARGET) begin
			tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
			if (!hold_issued && items_sent >= 150) begin
				rx_hold_req <= 1'b1;
				hold_issued = 1'b1;
			end
			run_sequence();
		end
		cmd_ch.valid <= 1'b0;

		wait_for_products();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errors == 0 && sb.expected_terms.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
